// ===== rtl/adaptive_link_sync_scheduler_defines.svh =====
// Assertion macros used by the adaptive link sync scheduler checker.
`ifndef ADAPTIVE_LINK_SYNC_SCHEDULER_DEFINES_SVH
`define ADAPTIVE_LINK_SYNC_SCHEDULER_DEFINES_SVH

// Same-cycle implication, sampled on clock, off while reset is high.
`define ALSS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off while reset is high.
`define ALSS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/alss_pkg.sv =====
// Types and constants of the adaptive link sync scheduler.
package alss_pkg;

   localparam int CNT_W = 7;
   localparam logic [CNT_W-1:0] RELOAD_CAP = 7'd64;

   // action codes
   localparam logic [1:0] ACT_TICK_1MS  = 2'd0;
   localparam logic [1:0] ACT_TICK_10MS = 2'd1;
   localparam logic [1:0] ACT_TRAFFIC   = 2'd2;

   // register indexes
   localparam logic [2:0] CSR_SYNC_ALL_PERIOD  = 3'd0;
   localparam logic [2:0] CSR_DOWNLINK_COUNT   = 3'd1;
   localparam logic [2:0] CSR_DOWNLINK_PRESENT = 3'd2;
   localparam logic [2:0] CSR_UPLINK_PRESENT   = 3'd3;
   localparam logic [2:0] CSR_SIDELINK_PRESENT = 3'd4;

   localparam logic [15:0] SYNC_ALL_PERIOD_RESET = 16'd1000;

   typedef struct packed {
      logic [1:0] action;
      logic [2:0] link_index;
      logic [7:0] downlink_online;
      logic       uplink_online;
      logic       sidelink_online;
   } req_type;

   typedef struct packed {
      logic [7:0] downlink_sync;
      logic       uplink_sync;
      logic       sidelink_sync;
      logic       sync_all;
   } rsp_type;

   // per-slot commands for one transaction
   typedef struct packed {
      logic tick_1ms;
      logic tick_10ms;
      logic restart;
   } link_ctrl_type;

endpackage

// ===== rtl/alss_link.sv =====
// One downlink slot: countdown, adaptive reload and grace flag.
module alss_link (
   input  logic                   clock,
   input  logic                   reset,
   input  alss_pkg::link_ctrl_type ctrl,
   output logic                   want
);

   logic [alss_pkg::CNT_W-1:0] countdown_ff, countdown_in;
   logic [alss_pkg::CNT_W-1:0] reload_ff, reload_in;
   logic                       grace_ff, grace_in;
   logic [alss_pkg::CNT_W-1:0] countdown_dec;

   always_comb begin
      countdown_dec = (countdown_ff != '0) ? countdown_ff - 1'b1 : countdown_ff;
      countdown_in  = countdown_ff;
      reload_in     = reload_ff;
      grace_in      = grace_ff;
      want          = 1'b0;
      if (ctrl.restart) begin
         countdown_in = '0;
         reload_in    = alss_pkg::CNT_W'(1);
         grace_in     = 1'b1;
      end else if (ctrl.tick_1ms) begin
         if (countdown_dec == '0) begin
            countdown_in = reload_ff;
            want         = 1'b1;
         end else begin
            countdown_in = countdown_dec;
         end
      end else if (ctrl.tick_10ms) begin
         if (grace_ff) begin
            grace_in = 1'b0;
         end else if (reload_ff < alss_pkg::RELOAD_CAP) begin
            reload_in = {reload_ff[alss_pkg::CNT_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         countdown_ff <= '0;
         reload_ff    <= alss_pkg::CNT_W'(1);
         grace_ff     <= 1'b1;
      end else begin
         countdown_ff <= countdown_in;
         reload_ff    <= reload_in;
         grace_ff     <= grace_in;
      end
   end

endmodule

// ===== rtl/alss_sync_all.sv =====
// Global countdown that forces a sync of all present links.
module alss_sync_all (
   input  logic        clock,
   input  logic        reset,
   input  logic        tick,
   input  logic [15:0] period,
   output logic        sync_all
);

   logic [15:0] countdown_ff, countdown_in;
   logic        expired;

   always_comb begin
      expired      = (countdown_ff == '0);
      sync_all     = tick & expired;
      countdown_in = countdown_ff;
      if (tick) begin
         countdown_in = expired ? period : countdown_ff - 16'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         countdown_ff <= '0;
      end else begin
         countdown_ff <= countdown_in;
      end
   end

endmodule

// ===== rtl/adaptive_link_sync_scheduler.sv =====
// Top level of the adaptive link sync scheduler.
//
// Usage:
//   req channel (valid/ready): one transaction per event, a 1 ms tick, a 10 ms
//   tick or traffic seen on one downlink slot, together with the current
//   online bits of the downlinks, the uplink and the sidelink.
//   rsp channel (valid/ready): exactly one transaction per request, in order,
//   telling which links to sync now; all fields are zero except on 1 ms ticks.
//   csr port: write enable, register index and 16-bit data, no wait state.
//   Write registers only while the block is idle.
// Pipeline:
//   A request waits in the input register; as it advances the per-slot
//   counters and the global countdown update and the result lands in the
//   output register, which drives rsp_valid and rsp_data. One transaction per
//   cycle is sustained while rsp_ready stays high, since all slots update
//   their state together.
// Reset: counters clear, reloads and grace flags return to 1, registers take
//   their defaults (period 1000, everything else 0).
// Stall: while rsp_ready is low the result holds; one more request waits in
//   the input register, after which req_ready drops until the result leaves.
module adaptive_link_sync_scheduler #(
   parameter int LINKS = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  alss_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output alss_pkg::rsp_type rsp_data,
   input  logic             csr_write_en,
   input  logic [2:0]       csr_index,
   input  logic [15:0]      csr_wdata
);

   // configuration registers
   logic [15:0] sync_all_period_ff;
   logic [3:0]  downlink_count_ff;
   logic [7:0]  downlink_present_ff;
   logic        uplink_present_ff;
   logic        sidelink_present_ff;

   // input stage
   logic              in_valid_ff, in_valid_in;
   alss_pkg::req_type in_data_ff;

   // output stage
   logic              rsp_valid_ff, rsp_valid_in;
   alss_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic req_accept;
   logic advance;
   logic is_1ms;
   logic is_10ms;
   logic is_traffic;
   logic sync_all;

   logic [LINKS-1:0] want;
   logic [LINKS-1:0] active;
   logic [7:0]       want8;
   logic [7:0]       active8;

   // Advance the input stage whenever the output register is free or draining.
   assign advance    = in_valid_ff & (~rsp_valid_ff | rsp_ready);
   assign req_ready  = ~in_valid_ff | advance;
   assign req_accept = req_valid & req_ready;

   assign is_1ms     = (in_data_ff.action == alss_pkg::ACT_TICK_1MS);
   assign is_10ms    = (in_data_ff.action == alss_pkg::ACT_TICK_10MS);
   assign is_traffic = (in_data_ff.action == alss_pkg::ACT_TRAFFIC);

   // Write the configuration registers; drop writes to unknown indexes.
   always_ff @(posedge clock) begin
      if (reset) begin
         sync_all_period_ff  <= alss_pkg::SYNC_ALL_PERIOD_RESET;
         downlink_count_ff   <= '0;
         downlink_present_ff <= '0;
         uplink_present_ff   <= 1'b0;
         sidelink_present_ff <= 1'b0;
      end else if (csr_write_en) begin
         case (csr_index)
            alss_pkg::CSR_SYNC_ALL_PERIOD:  sync_all_period_ff  <= csr_wdata;
            alss_pkg::CSR_DOWNLINK_COUNT:   downlink_count_ff   <= csr_wdata[3:0];
            alss_pkg::CSR_DOWNLINK_PRESENT: downlink_present_ff <= csr_wdata[7:0];
            alss_pkg::CSR_UPLINK_PRESENT:   uplink_present_ff   <= csr_wdata[0];
            alss_pkg::CSR_SIDELINK_PRESENT: sidelink_present_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Global forced-sync countdown.
   alss_sync_all u_sync_all (
      .clock    (clock),
      .reset    (reset),
      .tick     (advance & is_1ms),
      .period   (sync_all_period_ff),
      .sync_all (sync_all)
   );

   // Per-slot countdowns, all updated in parallel on the same transaction.
   for (genvar g = 0; g < LINKS; g++) begin : g_link
      alss_pkg::link_ctrl_type ctrl;

      // A slot counts only when below the active count; a count above LINKS
      // saturates for free since g never reaches LINKS.
      assign active[g]      = (4'(g) < downlink_count_ff);
      assign ctrl.tick_1ms  = advance & is_1ms & active[g];
      assign ctrl.tick_10ms = advance & is_10ms & active[g];
      // Traffic restarts the slot even when it is not active.
      assign ctrl.restart   = advance & is_traffic & ({1'b0, in_data_ff.link_index} == 4'(g));

      alss_link u_link (
         .clock (clock),
         .reset (reset),
         .ctrl  (ctrl),
         .want  (want[g])
      );
   end

   // Map slots onto the 8-bit result; slots beyond LINKS read as idle.
   for (genvar b = 0; b < 8; b++) begin : g_bit
      if (b < LINKS) begin : g_used
         assign want8[b]   = want[b];
         assign active8[b] = active[b];
      end else begin : g_unused
         assign want8[b]   = 1'b0;
         assign active8[b] = 1'b0;
      end
   end

   // Build the result; it is all zero unless this is a 1 ms tick.
   always_comb begin
      rsp_data_in.sync_all      = sync_all;
      rsp_data_in.downlink_sync = downlink_present_ff & active8 & ({8{sync_all}}
                                  | (want8 & in_data_ff.downlink_online));
      rsp_data_in.uplink_sync   = is_1ms & uplink_present_ff
                                  & (in_data_ff.uplink_online | sync_all);
      rsp_data_in.sidelink_sync = is_1ms & sidelink_present_ff
                                  & (in_data_ff.sidelink_online | sync_all);
   end

   assign in_valid_in  = req_accept | (in_valid_ff & ~advance);
   assign rsp_valid_in = advance | (rsp_valid_ff & ~rsp_ready);

   // Hold control state of both stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture payloads; hold them while stalled.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/alss_checker.sv =====
// Port-level checker of the adaptive link sync scheduler and its bind.
`include "adaptive_link_sync_scheduler_defines.svh"

module alss_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input alss_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input alss_pkg::rsp_type rsp_data
);

   // A stalled result holds.
   `ALSS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "stalled result changed")

   // Back-pressure on requests only comes from a stalled result.
   `ALSS_ASSERT_NOW(a_req_stall_cause, !req_ready, rsp_valid && !rsp_ready, "req_ready low without stalled result")

   // A fresh result follows an accepted request that went through the input register.
   `ALSS_ASSERT_NOW(a_rsp_latency, $rose(rsp_valid), $past(req_valid && req_ready, 2), "result without matching request")

   // A waiting request holds until it is taken.
   `ALSS_ASSERT_NEXT(a_req_hold, req_valid && !req_ready, req_valid && $stable(req_data), "waiting request changed")

endmodule

bind adaptive_link_sync_scheduler alss_checker u_alss_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ===== tb/sv/adaptive_link_sync_scheduler_test.sv =====
// Self-checking testbench of the adaptive link sync scheduler: directed table, then random phases.
module adaptive_link_sync_scheduler_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS         = 8;
   localparam int RANDOM_PHASES = 10;
   localparam int PHASE_ITEMS   = 145;
   localparam int CYCLE_LIMIT   = 400000;

   // action code the block must ignore, and a register index it does not decode
   localparam logic [1:0] ACT_UNUSED = 2'd3;
   localparam logic [2:0] CSR_UNUSED = 3'd5;

   localparam alss_pkg::rsp_type NO_SYNC       = '0;
   localparam alss_pkg::rsp_type FORCED_EMPTY  =
      alss_pkg::rsp_type'({8'h00, 1'b0, 1'b0, 1'b1});
   localparam alss_pkg::rsp_type FORCED_ALL_ON =
      alss_pkg::rsp_type'({8'hFF, 1'b1, 1'b1, 1'b1});

   // --------------------------------------------------------------------------
   // Clock, reset and the block's ports; every input starts at a known value.
   // --------------------------------------------------------------------------
   logic              clock        = 1'b0;
   logic              reset        = 1'b1;
   logic              req_valid    = 1'b0;
   logic              req_ready;
   alss_pkg::req_type req_data     = '0;
   logic              rsp_valid;
   logic              rsp_ready    = 1'b0;
   alss_pkg::rsp_type rsp_data;
   logic              csr_write_en = 1'b0;
   logic [2:0]        csr_index    = '0;
   logic [15:0]       csr_wdata    = '0;

   always #4 clock = ~clock;

   adaptive_link_sync_scheduler #(
      .LINKS(SLOTS)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_write_en(csr_write_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   // --------------------------------------------------------------------------
   // Scheduler shadow: register copies and per-slot countdown state.
   // --------------------------------------------------------------------------
   logic [15:0]                period_reg;
   logic [3:0]                 count_reg;
   logic [7:0]                 present_reg;
   logic                       up_present_reg;
   logic                       side_present_reg;

   logic [15:0]                all_left;
   logic [alss_pkg::CNT_W-1:0] slot_left   [SLOTS];
   logic [alss_pkg::CNT_W-1:0] slot_reload [SLOTS];
   logic                       slot_grace  [SLOTS];

   alss_pkg::rsp_type pending_syncs[$];   // sync decisions still owed, oldest first
   int                failures    = 0;
   int                cycle_count = 0;

   // Advance the shadow by one request and return the sync decision it causes.
   function automatic alss_pkg::rsp_type schedule_syncs(input alss_pkg::req_type r);
      alss_pkg::rsp_type plan;
      int                active;
      logic              fire;
      plan   = '0;
      active = (count_reg > SLOTS) ? SLOTS : int'(count_reg);
      case (r.action)
         alss_pkg::ACT_TICK_1MS: begin
            // global countdown: zero forces a sync of everything present
            if (all_left == 0) begin
               plan.sync_all = 1'b1;
               all_left      = period_reg;
            end else begin
               all_left = all_left - 1'b1;
            end
            for (int t = 0; t < active; t++) begin
               fire = 1'b0;
               if (slot_left[t] != 0)
                  slot_left[t] = slot_left[t] - 1'b1;
               if (slot_left[t] == 0) begin
                  slot_left[t] = slot_reload[t];
                  fire         = 1'b1;
               end
               if (present_reg[t] && (plan.sync_all || (fire && r.downlink_online[t])))
                  plan.downlink_sync[t] = 1'b1;
            end
            plan.uplink_sync   = up_present_reg & (r.uplink_online | plan.sync_all);
            plan.sidelink_sync = side_present_reg & (r.sidelink_online | plan.sync_all);
         end
         alss_pkg::ACT_TICK_10MS: begin
            // burn the grace tick first, then double up to the cap
            for (int t = 0; t < active; t++) begin
               if (slot_grace[t])
                  slot_grace[t] = 1'b0;
               else if (slot_reload[t] < alss_pkg::RELOAD_CAP)
                  slot_reload[t] = slot_reload[t] << 1;
            end
         end
         alss_pkg::ACT_TRAFFIC: begin
            // traffic restarts the slot even when it lies beyond the active count
            slot_left[r.link_index]   = '0;
            slot_reload[r.link_index] = alss_pkg::CNT_W'(1);
            slot_grace[r.link_index]  = 1'b1;
         end
         default: ;
      endcase
      return plan;
   endfunction

   // --------------------------------------------------------------------------
   // Directed stimulus table: register writes and requests, some with the
   // decision typed in, the rest left to the shadow.
   // --------------------------------------------------------------------------
   typedef enum logic {ROW_WRITE, ROW_ITEM} row_kind_type;

   typedef struct {
      row_kind_type      kind;
      logic [2:0]        reg_index;
      logic [15:0]       reg_value;
      alss_pkg::req_type item;
      logic              typed;
      alss_pkg::rsp_type want;
   } plan_row_type;

   plan_row_type directed_plan[$];

   function automatic plan_row_type write_row(input logic [2:0] idx, input logic [15:0] value);
      plan_row_type row;
      row           = '{kind: ROW_WRITE, reg_index: idx, reg_value: value,
                        item: '0, typed: 1'b0, want: '0};
      return row;
   endfunction

   function automatic plan_row_type item_row(input logic [1:0] act, input logic [2:0] idx,
                                             input logic [7:0] online, input logic up,
                                             input logic side, input logic typed = 1'b0,
                                             input alss_pkg::rsp_type want = '0);
      plan_row_type row;
      row.kind      = ROW_ITEM;
      row.reg_index = '0;
      row.reg_value = '0;
      row.item      = '{action: act, link_index: idx, downlink_online: online,
                        uplink_online: up, sidelink_online: side};
      row.typed     = typed;
      row.want      = want;
      return row;
   endfunction

   // --------------------------------------------------------------------------
   // Driver helpers.
   // --------------------------------------------------------------------------

   // Write one register; hold the strobe for exactly one edge, then release it
   // on the following edge so back-to-back writes never collide in one step.
   task automatic write_csr(input logic [2:0] idx, input logic [15:0] value);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         alss_pkg::CSR_SYNC_ALL_PERIOD:  period_reg       = value;
         alss_pkg::CSR_DOWNLINK_COUNT:   count_reg        = value[3:0];
         alss_pkg::CSR_DOWNLINK_PRESENT: present_reg      = value[7:0];
         alss_pkg::CSR_UPLINK_PRESENT:   up_present_reg   = value[0];
         alss_pkg::CSR_SIDELINK_PRESENT: side_present_reg = value[0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Offer one request, hold it until the handshake, record what it owes, then
   // drop valid for the requested gap. With no gap, valid stays high for the
   // next transaction.
   task automatic send_item(input alss_pkg::req_type item, input int gap, input logic typed,
                            input alss_pkg::rsp_type want);
      alss_pkg::rsp_type predicted;
      req_data  <= item;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = schedule_syncs(item);
      pending_syncs.push_back(typed ? want : predicted);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stop sending and wait until every owed decision has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_syncs.size() != 0) @(posedge clock);
   endtask

   task automatic report_mismatch(input string field, input logic [7:0] want_v,
                                  input logic [7:0] got_v);
      failures++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want_v, got_v);
   endtask

   // --------------------------------------------------------------------------
   // Receiver: switch stall pattern whenever the 6-bit tick wraps - always ready, coin flip,
   // ready when both low tick bits are set, or long stalls, ready only when the low five bits are >= 24.
   // --------------------------------------------------------------------------
   logic [5:0] rx_tick = '0;
   int         rx_mode = 0;

   always @(posedge clock) begin
      if (rx_tick == 0)
         rx_mode = $urandom_range(0, 3);
      case (rx_mode)
         0:       rsp_ready <= 1'b1;
         1:       rsp_ready <= 1'($urandom_range(0, 1));
         2:       rsp_ready <= (rx_tick[1:0] == 2'b11);
         default: rsp_ready <= (rx_tick[4:0] >= 5'd24);
      endcase
      rx_tick = rx_tick + 1'b1;
   end

   // --------------------------------------------------------------------------
   // Result checker: compare each accepted transaction with the oldest owed
   // decision, field by field.
   // --------------------------------------------------------------------------
   always @(posedge clock) begin : check_results
      alss_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_syncs.size() == 0) begin
            failures++;
            $display("%0t: unexpected result %h, expected none", $time, rsp_data);
         end else begin
            want = pending_syncs.pop_front();
            if (rsp_data.downlink_sync !== want.downlink_sync)
               report_mismatch("downlink_sync", want.downlink_sync, rsp_data.downlink_sync);
            if (rsp_data.uplink_sync !== want.uplink_sync)
               report_mismatch("uplink_sync", 8'(want.uplink_sync),
                               8'(rsp_data.uplink_sync));
            if (rsp_data.sidelink_sync !== want.sidelink_sync)
               report_mismatch("sidelink_sync", 8'(want.sidelink_sync),
                               8'(rsp_data.sidelink_sync));
            if (rsp_data.sync_all !== want.sync_all)
               report_mismatch("sync_all", 8'(want.sync_all), 8'(rsp_data.sync_all));
         end
      end
   end

   // Watchdog: give up if the run hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time, pending_syncs.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   // --------------------------------------------------------------------------
   // Stimulus.
   // --------------------------------------------------------------------------
   initial begin : stimulus
      alss_pkg::req_type item;
      int                gap;
      int                burst_left;
      int                pick;
      int                traffic_pct;
      logic              steady;
      logic [15:0]       period_v;
      logic [3:0]        count_v;
      logic [7:0]        present_v;
      logic              up_v;
      logic              side_v;

      // shadow starts in the reset state
      period_reg       = alss_pkg::SYNC_ALL_PERIOD_RESET;
      count_reg        = '0;
      present_reg      = '0;
      up_present_reg   = 1'b0;
      side_present_reg = 1'b0;
      all_left         = '0;
      for (int t = 0; t < SLOTS; t++) begin
         slot_left[t]   = '0;
         slot_reload[t] = alss_pkg::CNT_W'(1);
         slot_grace[t]  = 1'b1;
      end

      // Directed part. Zero period first: every 1 ms tick forces a sync, and
      // with nothing present only sync_all shows.
      directed_plan.push_back(write_row(alss_pkg::CSR_SYNC_ALL_PERIOD, 16'd0));
      directed_plan.push_back(item_row(alss_pkg::ACT_TICK_1MS, 3'd0, 8'hFF, 1'b1, 1'b1,
                                       1'b1, FORCED_EMPTY));
      directed_plan.push_back(item_row(alss_pkg::ACT_TICK_1MS, 3'd7, 8'h00, 1'b0, 1'b0,
                                       1'b1, FORCED_EMPTY));
      // other actions always answer with all fields clear
      directed_plan.push_back(item_row(alss_pkg::ACT_TICK_10MS, 3'd0, 8'hFF, 1'b1, 1'b1,
                                       1'b1, NO_SYNC));
      directed_plan.push_back(item_row(alss_pkg::ACT_TRAFFIC, 3'd7, 8'h00, 1'b0, 1'b0,
                                       1'b1, NO_SYNC));
      directed_plan.push_back(item_row(ACT_UNUSED, 3'd5, 8'hFF, 1'b1, 1'b1, 1'b1, NO_SYNC));
      // everything attached: a forced sync reaches offline links too
      directed_plan.push_back(write_row(alss_pkg::CSR_DOWNLINK_COUNT, 16'd8));
      directed_plan.push_back(write_row(alss_pkg::CSR_DOWNLINK_PRESENT, 16'h00FF));
      directed_plan.push_back(write_row(alss_pkg::CSR_UPLINK_PRESENT, 16'd1));
      directed_plan.push_back(write_row(alss_pkg::CSR_SIDELINK_PRESENT, 16'd1));
      directed_plan.push_back(item_row(alss_pkg::ACT_TICK_1MS, 3'd0, 8'h00, 1'b0, 1'b0,
                                       1'b1, FORCED_ALL_ON));
      directed_plan.push_back(write_row(alss_pkg::CSR_SYNC_ALL_PERIOD, 16'd2));
      directed_plan.push_back(item_row(alss_pkg::ACT_TICK_1MS, 3'd1, 8'hFF, 1'b0, 1'b1,
                                       1'b1, FORCED_ALL_ON));
      // countdown-driven syncs, grace tick, doubling and traffic restart
      directed_plan.push_back(item_row(alss_pkg::ACT_TICK_1MS, 3'd2, 8'hFF, 1'b1, 1'b0));
      directed_plan.push_back(item_row(alss_pkg::ACT_TICK_10MS, 3'd3, 8'h00, 1'b0, 1'b0));
      directed_plan.push_back(item_row(alss_pkg::ACT_TICK_10MS, 3'd4, 8'hFF, 1'b1, 1'b1));
      directed_plan.push_back(item_row(alss_pkg::ACT_TRAFFIC, 3'd0, 8'h0F, 1'b1, 1'b0));
      directed_plan.push_back(item_row(alss_pkg::ACT_TICK_10MS, 3'd6, 8'hF0, 1'b0, 1'b1));
      directed_plan.push_back(item_row(alss_pkg::ACT_TICK_1MS, 3'd0, 8'h5A, 1'b1, 1'b1));
      directed_plan.push_back(item_row(alss_pkg::ACT_TICK_1MS, 3'd0, 8'hA5, 1'b0, 1'b1));
      directed_plan.push_back(item_row(alss_pkg::ACT_TICK_1MS, 3'd0, 8'hFF, 1'b1, 1'b0));
      // oversized count saturates; partial present masks
      directed_plan.push_back(write_row(alss_pkg::CSR_DOWNLINK_PRESENT, 16'h000F));
      directed_plan.push_back(write_row(alss_pkg::CSR_UPLINK_PRESENT, 16'd0));
      directed_plan.push_back(write_row(alss_pkg::CSR_DOWNLINK_COUNT, 16'd15));
      directed_plan.push_back(item_row(alss_pkg::ACT_TICK_1MS, 3'd0, 8'hFF, 1'b1, 1'b1));
      directed_plan.push_back(item_row(alss_pkg::ACT_TRAFFIC, 3'd3, 8'h00, 1'b0, 1'b0));
      directed_plan.push_back(item_row(alss_pkg::ACT_TICK_1MS, 3'd0, 8'hF0, 1'b1, 1'b0));
      directed_plan.push_back(item_row(alss_pkg::ACT_TICK_1MS, 3'd0, 8'hFF, 1'b0, 1'b1));
      // no active slots: 10 ms ticks touch nothing, traffic still restarts
      directed_plan.push_back(write_row(alss_pkg::CSR_DOWNLINK_COUNT, 16'd0));
      directed_plan.push_back(write_row(alss_pkg::CSR_DOWNLINK_PRESENT, 16'h0000));
      directed_plan.push_back(write_row(CSR_UNUSED, 16'hFFFF));
      directed_plan.push_back(item_row(alss_pkg::ACT_TICK_10MS, 3'd0, 8'hFF, 1'b1, 1'b1));
      directed_plan.push_back(item_row(alss_pkg::ACT_TRAFFIC, 3'd6, 8'hFF, 1'b1, 1'b1));
      directed_plan.push_back(item_row(alss_pkg::ACT_TICK_1MS, 3'd0, 8'hFF, 1'b1, 1'b1));
      directed_plan.push_back(write_row(alss_pkg::CSR_DOWNLINK_COUNT, 16'd8));
      directed_plan.push_back(write_row(alss_pkg::CSR_DOWNLINK_PRESENT, 16'h00FF));
      directed_plan.push_back(write_row(alss_pkg::CSR_UPLINK_PRESENT, 16'd1));
      directed_plan.push_back(write_row(alss_pkg::CSR_SIDELINK_PRESENT, 16'd0));
      directed_plan.push_back(item_row(alss_pkg::ACT_TICK_1MS, 3'd0, 8'h3C, 1'b1, 1'b1));
      directed_plan.push_back(item_row(alss_pkg::ACT_TICK_10MS, 3'd0, 8'h00, 1'b0, 1'b0));
      directed_plan.push_back(item_row(alss_pkg::ACT_TICK_1MS, 3'd0, 8'hC3, 1'b0, 1'b1));

      // hold reset high, then release it for good
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Walk the table; registers change only once the block has gone idle.
      foreach (directed_plan[i]) begin
         if (directed_plan[i].kind == ROW_WRITE) begin
            drain_results();
            write_csr(directed_plan[i].reg_index, directed_plan[i].reg_value);
         end else begin
            send_item(directed_plan[i].item, $urandom_range(0, 2), directed_plan[i].typed,
                      directed_plan[i].want);
         end
      end

      // Random phases: each starts idle with a fresh register setting, the
      // extremes pinned on some phases. The last phase loads the longest period.
      burst_left = 0;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         period_v    = 16'($urandom_range(0, 60));
         count_v     = 4'($urandom_range(0, 8));
         present_v   = 8'($urandom_range(0, 255));
         up_v        = 1'($urandom_range(0, 1));
         side_v      = 1'($urandom_range(0, 1));
         traffic_pct = 10;
         case (phase)
            0: begin
               period_v  = 16'd0;
               count_v   = 4'd8;
               present_v = 8'hFF;
               up_v      = 1'b1;
               side_v    = 1'b1;
            end
            1: begin
               period_v    = 16'd1;
               count_v     = 4'd15;
               traffic_pct = 2;
            end
            2: count_v = 4'($urandom_range(9, 14));
            3: begin
               count_v   = 4'd0;
               present_v = 8'hFF;
            end
            4: begin
               period_v    = 16'd5;
               count_v     = 4'd8;
               present_v   = 8'h00;
               up_v        = 1'b0;
               side_v      = 1'b0;
               traffic_pct = 1;
            end
            6: begin
               count_v     = 4'd8;
               traffic_pct = 2;
            end
            RANDOM_PHASES - 1: begin
               period_v  = 16'hFFFF;
               count_v   = 4'd8;
               present_v = 8'hFF;
            end
            default: ;
         endcase

         // pause the sender until every owed result is back, then reprogram
         drain_results();
         write_csr(alss_pkg::CSR_SYNC_ALL_PERIOD, period_v);
         write_csr(alss_pkg::CSR_DOWNLINK_COUNT, 16'(count_v));
         write_csr(alss_pkg::CSR_DOWNLINK_PRESENT, 16'(present_v));
         write_csr(alss_pkg::CSR_UPLINK_PRESENT, 16'(up_v));
         write_csr(alss_pkg::CSR_SIDELINK_PRESENT, 16'(side_v));

         // some phases send back to back with no gaps at all
         steady = (phase % 4 == 2);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // mostly ticks so countdowns and reloads run deep; rare junk actions
            pick = $urandom_range(0, 99);
            if (pick < 3)
               item.action = ACT_UNUSED;
            else if (pick < 3 + traffic_pct)
               item.action = alss_pkg::ACT_TRAFFIC;
            else if (pick < 25 + traffic_pct)
               item.action = alss_pkg::ACT_TICK_10MS;
            else
               item.action = alss_pkg::ACT_TICK_1MS;
            item.link_index = 3'($urandom_range(0, 7));
            case ($urandom_range(0, 3))
               0:       item.downlink_online = 8'hFF;
               1:       item.downlink_online = 8'h00;
               default: item.downlink_online = 8'($urandom_range(0, 255));
            endcase
            item.uplink_online   = 1'($urandom_range(0, 1));
            item.sidelink_online = 1'($urandom_range(0, 1));

            // bursts of random length, gap after each burst except in steady phases
            if (burst_left == 0)
               burst_left = $urandom_range(1, 24);
            burst_left--;
            gap = (burst_left == 0 && !steady) ? $urandom_range(1, 8) : 0;
            send_item(item, gap, 1'b0, NO_SYNC);
         end
      end

      // let the block settle after the last owed result, then judge the run
      drain_results();
      repeat (8) @(posedge clock);
      if (failures == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/alss_pkg.sv
rtl/alss_link.sv
rtl/alss_sync_all.sv
rtl/adaptive_link_sync_scheduler.sv
rtl/alss_checker.sv
tb/sv/adaptive_link_sync_scheduler_test.sv
